// ===== rtl/ptea_pkg.sv =====
// ----------------------------------------------------------------------------
// ptea_pkg
// shared constants, codes and types of the port table allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ptea_pkg;

   // default sizes
   localparam int unsigned NUM_PORTS_DEF  = 65536;
   localparam int unsigned OWNER_BITS_DEF = 8;

   // fixed field widths
   localparam int unsigned ACTION_W = 3;
   localparam int unsigned PORT_W   = 16;
   localparam int unsigned OWNER_W  = 8;

   localparam logic [PORT_W-1:0] PORT_TOP   = 16'hFFFF;
   localparam logic [PORT_W-1:0] BASE_RESET = 16'd49152;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP     = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_FREE_OWNER = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_ALLOCATE   = 3'd4;

   // command queue
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      OP_REGISTER,
      OP_UNREGISTER,
      OP_LOOKUP,
      OP_FREE_OWNER,
      OP_ALLOCATE,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [PORT_W-1:0]   port;
      logic [OWNER_W-1:0]  owner;       // already masked to the owner width
      logic                in_table;
      logic                owner_zero;
   } cmd_type;

   typedef struct packed {
      logic                valid;
      logic                ok;
      logic [PORT_W-1:0]   port;
      logic [OWNER_W-1:0]  owner;
   } rsp_type;

   typedef struct packed {
      logic                clearing;
   } eng_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW,
      ST_FREE,
      ST_ALLOC_A,
      ST_ALLOC_B
   } eng_state_type;

   function automatic logic port_in_table(logic [PORT_W-1:0] p, int unsigned n);
      return ({1'b0, p} < 17'(n));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/port_table_ephemeral_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// port_table_ephemeral_allocator_unit
// port ownership table with register, lookup, release and ephemeral allocation
// ----------------------------------------------------------------------------
// usage
//   request words enter on start/req_* and are taken at a clock edge where
//   start is high and busy is low. every request yields exactly one result
//   word, shown for one cycle on rsp_* with rsp_strobe high; the receiver
//   has no way to hold it off and need not, results never pile up.
//   csr_we/csr_wdata set the ephemeral base; write it only while idle.
// timing
//   an intake stage and a two-deep command queue sit in front of the table
//   engine, so busy only rises when the queue is full or during clearing.
//   register, unregister and lookup are one read-modify-write of the table
//   ram. free-owner walks the whole table, one entry per cycle. allocate
//   walks from the next-ephemeral pointer, one port per cycle. requests
//   that fail early (owner zero, port beyond table, unused action) are
//   answered from the idle state without a read-modify-write.
// reset
//   synchronous; afterwards the engine writes every table entry to zero,
//   one per cycle, with busy held high. configuration writes are taken
//   during that pass.
// ----------------------------------------------------------------------------
`default_nettype none

module port_table_ephemeral_allocator_unit import ptea_pkg::*; #(
   parameter int unsigned NUM_PORTS  = NUM_PORTS_DEF,
   parameter int unsigned OWNER_BITS = OWNER_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request channel
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [PORT_W-1:0]   req_port,
   input  wire logic [OWNER_W-1:0]  req_owner,
   // result channel
   output logic                     rsp_strobe,
   output logic                     rsp_ok,
   output logic [PORT_W-1:0]        rsp_port_out,
   output logic [OWNER_W-1:0]       rsp_owner_out,
   // configuration
   input  wire logic                csr_we,
   input  wire logic [PORT_W-1:0]   csr_wdata
);

   logic            push;
   cmd_type         push_cmd;
   logic            pop;
   cmd_type         q_head;
   logic            q_empty;
   logic            q_full;
   rsp_type         rsp;
   eng_status_type  status;

   // intake: decode and classify the request word
   ptea_front #(
      .NUM_PORTS  (NUM_PORTS),
      .OWNER_BITS (OWNER_BITS)
   ) u_front (
      .start      (start),
      .req_action (req_action),
      .req_port   (req_port),
      .req_owner  (req_owner),
      .q_full     (q_full),
      .status     (status),
      .busy       (busy),
      .push       (push),
      .cmd        (push_cmd)
   );

   // decouples intake from the table engine
   ptea_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (q_head),
      .empty    (q_empty),
      .full     (q_full)
   );

   // table engine with the owner ram, clearing pass and scans
   ptea_engine #(
      .NUM_PORTS  (NUM_PORTS),
      .OWNER_BITS (OWNER_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .pop       (pop),
      .rsp       (rsp),
      .status    (status)
   );

   // result word straight from the engine's output register
   assign rsp_strobe    = rsp.valid;
   assign rsp_ok        = rsp.ok;
   assign rsp_port_out  = rsp.port;
   assign rsp_owner_out = rsp.owner;

   // no result can come out while the table is still being cleared
   a_no_rsp_while_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !rsp_strobe)
      else $error("result strobe during clearing pass");

   // a nonzero port only comes with a successful allocation
   a_port_implies_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_port_out != '0)) |-> rsp_ok)
      else $error("port reported without success");

   // failures answer with zero port and zero owner
   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> ((rsp_port_out == '0) && (rsp_owner_out == '0)))
      else $error("failed result carries data");

endmodule

`default_nettype wire

// ===== rtl/ptea_ram.sv =====
// ----------------------------------------------------------------------------
// ptea_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ptea_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/ptea_front.sv =====
// ----------------------------------------------------------------------------
// ptea_front
// request intake: decodes the action and pre-classifies the word
// ----------------------------------------------------------------------------
`default_nettype none

module ptea_front import ptea_pkg::*; #(
   parameter int unsigned NUM_PORTS  = NUM_PORTS_DEF,
   parameter int unsigned OWNER_BITS = OWNER_BITS_DEF
) (
   input  wire logic                start,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [PORT_W-1:0]   req_port,
   input  wire logic [OWNER_W-1:0]  req_owner,
   input  wire logic                q_full,
   input  wire eng_status_type      status,
   output logic                     busy,
   output logic                     push,
   output cmd_type                  cmd
);

   localparam logic [OWNER_W-1:0] OWNER_MASK =
      (OWNER_BITS >= OWNER_W) ? {OWNER_W{1'b1}} : OWNER_W'((1 << OWNER_BITS) - 1);

   logic [OWNER_W-1:0] owner_m;

   assign busy    = q_full || status.clearing;
   assign push    = start && !busy;
   assign owner_m = req_owner & OWNER_MASK;

   always_comb begin
      cmd.port       = req_port;
      cmd.owner      = owner_m;
      cmd.in_table   = port_in_table(req_port, NUM_PORTS);
      cmd.owner_zero = (owner_m == '0);
      unique case (req_action)
         ACT_REGISTER:   cmd.op = OP_REGISTER;
         ACT_UNREGISTER: cmd.op = OP_UNREGISTER;
         ACT_LOOKUP:     cmd.op = OP_LOOKUP;
         ACT_FREE_OWNER: cmd.op = OP_FREE_OWNER;
         ACT_ALLOCATE:   cmd.op = OP_ALLOCATE;
         default:        cmd.op = OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/ptea_queue.sv =====
// ----------------------------------------------------------------------------
// ptea_queue
// short command queue between intake and table engine
// ----------------------------------------------------------------------------
`default_nettype none

module ptea_queue import ptea_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty,
   output logic         full
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ptea_engine.sv =====
// ----------------------------------------------------------------------------
// ptea_engine
// table engine: clearing pass, read-modify-write and table scans
// ----------------------------------------------------------------------------
`default_nettype none

module ptea_engine import ptea_pkg::*; #(
   parameter int unsigned NUM_PORTS  = NUM_PORTS_DEF,
   parameter int unsigned OWNER_BITS = OWNER_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [PORT_W-1:0] csr_wdata,
   input  wire logic              q_empty,
   input  wire cmd_type           q_head,
   output logic                   pop,
   output rsp_type                rsp,
   output eng_status_type         status
);

   localparam int unsigned AW = $clog2(NUM_PORTS);
   localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(NUM_PORTS - 1);

   eng_state_type          state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   logic [PORT_W-1:0]      ptr_ff, ptr_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [PORT_W-1:0]      chk_addr_ff, chk_addr_in;
   logic                   scan_end_ff, scan_end_in;
   logic [PORT_W-1:0]      next_eph_ff, next_eph_in;
   logic [PORT_W-1:0]      base_ff, base_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [OWNER_BITS-1:0]  wr_data;
   logic [AW-1:0]          rd_addr;
   logic [OWNER_BITS-1:0]  rd_data;
   logic [OWNER_BITS-1:0]  owner_w;
   logic                   hit;

   ptea_ram #(
      .WIDTH (OWNER_BITS),
      .DEPTH (NUM_PORTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign owner_w         = OWNER_BITS'(cmd_ff.owner);
   assign hit             = chk_vld_ff && (rd_data == '0);
   assign rsp             = rsp_ff;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign base_in         = csr_we ? csr_wdata : base_ff;

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      ptr_in      = ptr_ff;
      chk_vld_in  = 1'b0;
      chk_addr_in = chk_addr_ff;
      scan_end_in = scan_end_ff;
      next_eph_in = next_eph_ff;
      rsp_in      = '0;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = chk_addr_ff[AW-1:0];
      wr_data     = '0;
      rd_addr     = ptr_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff[AW-1:0];
            if (ptr_ff == LAST_PORT) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               cmd_in  = q_head;
               rd_addr = q_head.port[AW-1:0];
               unique case (q_head.op) inside
                  OP_REGISTER: begin
                     if (q_head.in_table && !q_head.owner_zero) begin
                        state_in = ST_RMW;
                     end else begin
                        rsp_in.valid = 1'b1;
                     end
                  end
                  OP_UNREGISTER, OP_LOOKUP: begin
                     if (q_head.in_table) begin
                        state_in = ST_RMW;
                     end else begin
                        rsp_in.valid = 1'b1;
                     end
                  end
                  OP_FREE_OWNER: begin
                     if (q_head.owner_zero) begin
                        rsp_in.valid = 1'b1;
                        rsp_in.ok    = 1'b1;
                     end else begin
                        ptr_in      = '0;
                        scan_end_in = 1'b0;
                        state_in    = ST_FREE;
                     end
                  end
                  OP_ALLOCATE: begin
                     if (q_head.owner_zero) begin
                        rsp_in.valid = 1'b1;
                     end else begin
                        ptr_in   = next_eph_ff;
                        state_in = ST_ALLOC_A;
                     end
                  end
                  default: begin
                     rsp_in.valid = 1'b1;
                  end
               endcase
            end
         end

         ST_RMW: begin
            wr_addr      = cmd_ff.port[AW-1:0];
            rsp_in.valid = 1'b1;
            state_in     = ST_IDLE;
            unique case (cmd_ff.op) inside
               OP_REGISTER: begin
                  if (rd_data == '0) begin
                     wr_en     = 1'b1;
                     wr_data   = owner_w;
                     rsp_in.ok = 1'b1;
                  end
               end
               OP_UNREGISTER: begin
                  if (rd_data != '0) begin
                     wr_en     = 1'b1;
                     rsp_in.ok = 1'b1;
                  end
               end
               OP_LOOKUP: begin
                  rsp_in.ok    = (rd_data != '0);
                  rsp_in.owner = OWNER_W'(rd_data);
               end
               default: begin
                  rsp_in.ok = 1'b0;
               end
            endcase
         end

         ST_FREE: begin
            // release the entry read last cycle if it belongs to the owner
            if (chk_vld_ff && (rd_data == owner_w)) begin
               wr_en = 1'b1;
            end
            if (scan_end_ff) begin
               rsp_in.valid = 1'b1;
               rsp_in.ok    = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               chk_vld_in  = 1'b1;
               chk_addr_in = ptr_ff;
               if (ptr_ff == LAST_PORT) begin
                  scan_end_in = 1'b1;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end

         ST_ALLOC_A, ST_ALLOC_B: begin
            if (hit) begin
               wr_en        = 1'b1;
               wr_data      = owner_w;
               rsp_in.valid = 1'b1;
               rsp_in.ok    = 1'b1;
               rsp_in.port  = chk_addr_ff;
               next_eph_in  = chk_addr_ff + 1'b1;
               state_in     = ST_IDLE;
            end else if ((state_ff == ST_ALLOC_A) ? (ptr_ff != PORT_TOP)
                                                  : (ptr_ff < next_eph_ff)) begin
               chk_vld_in  = port_in_table(ptr_ff, NUM_PORTS);
               chk_addr_in = ptr_ff;
               ptr_in      = ptr_ff + 1'b1;
            end else if (state_ff == ST_ALLOC_A) begin
               // upper range exhausted, wrap to the configured base
               ptr_in   = base_ff;
               state_in = ST_ALLOC_B;
            end else begin
               rsp_in.valid = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         ptr_ff      <= '0;
         chk_vld_ff  <= 1'b0;
         scan_end_ff <= 1'b0;
         next_eph_ff <= BASE_RESET;
         base_ff     <= BASE_RESET;
         rsp_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         chk_vld_ff  <= chk_vld_in;
         scan_end_ff <= scan_end_in;
         next_eph_ff <= next_eph_in;
         base_ff     <= base_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      chk_addr_ff <= chk_addr_in;
   end

endmodule

`default_nettype wire
